### sv/qenc_pkg.sv
// Shared types, codes and reset values for the quadrature encoder unit.
// Used by every module but the divider and checker; depends on nothing.
package qenc_pkg;

  localparam int unsigned INTERVAL_SAMPLES_DEF = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Event source codes
  localparam logic [1:0] ACT_PHASE_A = 2'd0;
  localparam logic [1:0] ACT_PHASE_B = 2'd1;
  localparam logic [1:0] ACT_BUTTON  = 2'd2;

  // Direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Button edge codes
  localparam logic [1:0] EDGE_NONE = 2'd0;
  localparam logic [1:0] EDGE_RISE = 2'd1;
  localparam logic [1:0] EDGE_FALL = 2'd2;

  // Result event codes
  localparam logic [1:0] EVT_CW       = 2'd0;
  localparam logic [1:0] EVT_CCW      = 2'd1;
  localparam logic [1:0] EVT_PRESSED  = 2'd2;
  localparam logic [1:0] EVT_RELEASED = 2'd3;

  // Speed multipliers
  localparam logic [3:0] SPEED_1 = 4'd1;
  localparam logic [3:0] SPEED_2 = 4'd2;
  localparam logic [3:0] SPEED_4 = 4'd4;
  localparam logic [3:0] SPEED_8 = 4'd8;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_REVERSAL = 3'd0;
  localparam logic [2:0] REG_FAST     = 3'd1;
  localparam logic [2:0] REG_MEDIUM   = 3'd2;
  localparam logic [2:0] REG_SLOW     = 3'd3;
  localparam logic [2:0] REG_HOLDOFF  = 3'd4;
  localparam logic [2:0] REG_START    = 3'd5;

  // Register reset values
  localparam logic [7:0]  RST_REVERSAL = 8'd2;
  localparam logic [15:0] RST_FAST     = 16'd20;
  localparam logic [15:0] RST_MEDIUM   = 16'd40;
  localparam logic [15:0] RST_SLOW     = 16'd80;
  localparam logic [15:0] RST_HOLDOFF  = 16'd500;
  localparam logic [31:0] RST_START    = 32'd0;

  typedef struct packed {
    logic [7:0]  reversal_steps;
    logic [15:0] fast_limit;
    logic [15:0] medium_limit;
    logic [15:0] slow_limit;
    logic [15:0] press_holdoff;
    logic [31:0] start_time;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic accum;
    logic div_start;
    logic set_speed;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic need_avg;
    logic has_result;
    logic div_done;
  } sts_t;

endpackage

### sv/qenc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath to average the step intervals.
module qenc_div #(
  parameter int unsigned DIVIDEND_W = 36,
  parameter int unsigned DIVISOR_W  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  qbit;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign qbit    = ~diff[DIVISOR_W+1];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], qbit};
      rem_d = qbit ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### sv/qenc_dp.sv
// Datapath: quadrature decode, reversal hysteresis, interval ring, speed
// select, button filter and result register. Depends on qenc_pkg, qenc_div.
module qenc_dp #(
  parameter int unsigned INTERVAL_SAMPLES = qenc_pkg::INTERVAL_SAMPLES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qenc_pkg::cfg_t              cfg_i,
  input  qenc_pkg::cmd_t              cmd_i,
  output qenc_pkg::sts_t              sts_o,
  input  logic [1:0]                  action_i,
  input  logic                        rising_i,
  input  logic                        phase_a_i,
  input  logic                        phase_b_i,
  input  logic [qenc_pkg::TIME_W-1:0] time_ms_i,
  output logic [1:0]                  event_res_o,
  output logic [3:0]                  step_speed_o
);

  localparam int unsigned TW     = qenc_pkg::TIME_W;
  localparam int unsigned FILL_W = $clog2(INTERVAL_SAMPLES + 1);
  localparam int unsigned POS_W  = (INTERVAL_SAMPLES > 1) ? $clog2(INTERVAL_SAMPLES) : 1;
  localparam int unsigned SUM_W  = TW + FILL_W;

  // Latched input word
  logic [1:0]    act_q;
  logic          rise_q, a_q, b_q;
  logic [TW-1:0] now_q;

  // Decoder state
  logic          last_a_q, last_b_q;
  logic [1:0]    dir_q;
  logic [7:0]    rev_cnt_q;
  logic [3:0]    speed_q;
  logic [1:0]    btn_q;
  logic [TW-1:0] prev_q;

  // Interval ring and running sum
  logic [TW-1:0]     ring_q [INTERVAL_SAMPLES];
  logic [POS_W-1:0]  pos_q, pos_next;
  logic [FILL_W-1:0] fill_q;
  logic [SUM_W-1:0]  sum_q;
  logic [TW-1:0]     dt_q, old_q;
  logic [1:0]        evt_q;
  logic [1:0]        out_evt_q;
  logic [3:0]        out_speed_q;

  logic [1:0]       step_dir, btn_edge, evt;
  logic             is_step, is_btn, same_dir, rev_accept, time_ok;
  logic             btn_new, btn_ok, fill_full;
  logic [8:0]       rev_next;
  logic [TW-1:0]    dt, since_start, old;
  logic             div_done;
  logic [SUM_W-1:0] avg;
  logic [3:0]       speed_sel;

  // Direction from the phase levels before and after the edge
  always_comb begin
    step_dir = qenc_pkg::DIR_NONE;
    if (act_q == qenc_pkg::ACT_PHASE_A && a_q != last_a_q) begin
      if (rise_q && a_q && !last_a_q) begin
        step_dir = b_q ? qenc_pkg::DIR_CW : qenc_pkg::DIR_CCW;
      end else if (!a_q && last_a_q) begin
        step_dir = b_q ? qenc_pkg::DIR_CCW : qenc_pkg::DIR_CW;
      end
    end else if (act_q == qenc_pkg::ACT_PHASE_B && b_q != last_b_q) begin
      if (rise_q && b_q && !last_b_q) begin
        step_dir = a_q ? qenc_pkg::DIR_CCW : qenc_pkg::DIR_CW;
      end else if (!b_q && last_b_q) begin
        step_dir = a_q ? qenc_pkg::DIR_CW : qenc_pkg::DIR_CCW;
      end
    end
  end

  assign is_step    = (step_dir != qenc_pkg::DIR_NONE);
  assign same_dir   = (dir_q == step_dir);
  assign rev_next   = {1'b0, rev_cnt_q} + 9'd1;
  assign rev_accept = rev_next > {1'b0, cfg_i.reversal_steps};
  assign time_ok    = now_q > prev_q;
  assign dt         = now_q - prev_q;

  assign is_btn      = (act_q == qenc_pkg::ACT_BUTTON);
  assign btn_edge    = rise_q ? qenc_pkg::EDGE_RISE : qenc_pkg::EDGE_FALL;
  assign btn_new     = (btn_edge != btn_q);
  assign since_start = now_q - cfg_i.start_time;
  assign btn_ok      = (now_q >= cfg_i.start_time) &&
                       (since_start > {16'd0, cfg_i.press_holdoff});

  assign fill_full = (fill_q == FILL_W'(INTERVAL_SAMPLES));
  // Below a full ring the slot at pos is logically empty
  assign old       = fill_full ? ring_q[pos_q] : '0;
  assign pos_next  = (pos_q == POS_W'(INTERVAL_SAMPLES - 1)) ? '0 : pos_q + POS_W'(1);

  always_comb begin
    if (is_btn) begin
      evt = rise_q ? qenc_pkg::EVT_RELEASED : qenc_pkg::EVT_PRESSED;
    end else begin
      evt = (step_dir == qenc_pkg::DIR_CW) ? qenc_pkg::EVT_CW : qenc_pkg::EVT_CCW;
    end
  end

  always_comb begin
    if (avg < {{(SUM_W-16){1'b0}}, cfg_i.fast_limit}) begin
      speed_sel = qenc_pkg::SPEED_8;
    end else if (avg < {{(SUM_W-16){1'b0}}, cfg_i.medium_limit}) begin
      speed_sel = qenc_pkg::SPEED_4;
    end else if (avg < {{(SUM_W-16){1'b0}}, cfg_i.slow_limit}) begin
      speed_sel = qenc_pkg::SPEED_2;
    end else begin
      speed_sel = qenc_pkg::SPEED_1;
    end
  end

  qenc_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (FILL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (avg)
  );

  assign sts_o.need_avg   = is_step && same_dir && time_ok;
  assign sts_o.has_result = (is_btn && btn_new && btn_ok) ||
                            (is_step && (same_dir || rev_accept));
  assign sts_o.div_done   = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q  <= 1'b0;
      last_b_q  <= 1'b0;
      dir_q     <= qenc_pkg::DIR_NONE;
      rev_cnt_q <= '0;
      speed_q   <= qenc_pkg::SPEED_1;
      btn_q     <= qenc_pkg::EDGE_NONE;
      prev_q    <= '0;
      pos_q     <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
    end else begin
      if (cmd_i.eval) begin
        if (act_q == qenc_pkg::ACT_PHASE_A || act_q == qenc_pkg::ACT_PHASE_B) begin
          last_a_q <= a_q;
          last_b_q <= b_q;
        end
        if (is_btn && btn_new) begin
          btn_q <= btn_edge;
        end
        if (is_step) begin
          prev_q <= now_q;
          if (same_dir) begin
            if (!time_ok) begin
              speed_q <= qenc_pkg::SPEED_1;
            end else begin
              pos_q <= pos_next;
              if (!fill_full) begin
                fill_q <= fill_q + FILL_W'(1);
              end
            end
          end else if (rev_accept) begin
            rev_cnt_q <= '0;
            dir_q     <= step_dir;
            speed_q   <= qenc_pkg::SPEED_1;
            pos_q     <= '0;
            fill_q    <= '0;
            sum_q     <= '0;
          end else begin
            rev_cnt_q <= rev_next[7:0];
          end
        end
      end
      if (cmd_i.accum) begin
        sum_q <= sum_q - {{FILL_W{1'b0}}, old_q} + {{FILL_W{1'b0}}, dt_q};
      end
      if (cmd_i.set_speed) begin
        speed_q <= speed_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      rise_q <= rising_i;
      a_q    <= phase_a_i;
      b_q    <= phase_b_i;
      now_q  <= time_ms_i;
    end
    if (cmd_i.eval) begin
      evt_q <= evt;
      dt_q  <= dt;
      old_q <= old;
      if (is_step && same_dir && time_ok) begin
        ring_q[pos_q] <= dt;
      end
    end
    if (cmd_i.push) begin
      out_evt_q   <= evt_q;
      out_speed_q <= speed_q;
    end
  end

  assign event_res_o  = out_evt_q;
  assign step_speed_o = out_speed_q;

endmodule

### sv/qenc_ctrl.sv
// Controller: sequences load and evaluate for each word, plus average and
// push where needed, and owns the output valid flag. Depends on qenc_pkg.
module qenc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  qenc_pkg::sts_t sts_i,
  output qenc_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EVAL  = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_START = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_PUSH  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.need_avg) begin
          state_d = ST_ACC;
        end else if (sts_i.has_result) begin
          state_d = ST_PUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = ST_START;
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.set_speed = 1'b1;
          state_d         = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### sv/qenc_cfg.sv
// APB-style register file for the encoder limits and start time.
// Depends on qenc_pkg.
module qenc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qenc_pkg::ADDR_W-1:0] paddr,
  input  logic [qenc_pkg::DATA_W-1:0] pwdata,
  output logic [qenc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output qenc_pkg::cfg_t              cfg_o
);

  qenc_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[qenc_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reversal_steps <= qenc_pkg::RST_REVERSAL;
      cfg_q.fast_limit     <= qenc_pkg::RST_FAST;
      cfg_q.medium_limit   <= qenc_pkg::RST_MEDIUM;
      cfg_q.slow_limit     <= qenc_pkg::RST_SLOW;
      cfg_q.press_holdoff  <= qenc_pkg::RST_HOLDOFF;
      cfg_q.start_time     <= qenc_pkg::RST_START;
    end else if (wr_en) begin
      case (idx)
        qenc_pkg::REG_REVERSAL: cfg_q.reversal_steps <= pwdata[7:0];
        qenc_pkg::REG_FAST:     cfg_q.fast_limit     <= pwdata[15:0];
        qenc_pkg::REG_MEDIUM:   cfg_q.medium_limit   <= pwdata[15:0];
        qenc_pkg::REG_SLOW:     cfg_q.slow_limit     <= pwdata[15:0];
        qenc_pkg::REG_HOLDOFF:  cfg_q.press_holdoff  <= pwdata[15:0];
        qenc_pkg::REG_START:    cfg_q.start_time     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      qenc_pkg::REG_REVERSAL: prdata = {24'd0, cfg_q.reversal_steps};
      qenc_pkg::REG_FAST:     prdata = {16'd0, cfg_q.fast_limit};
      qenc_pkg::REG_MEDIUM:   prdata = {16'd0, cfg_q.medium_limit};
      qenc_pkg::REG_SLOW:     prdata = {16'd0, cfg_q.slow_limit};
      qenc_pkg::REG_HOLDOFF:  prdata = {16'd0, cfg_q.press_holdoff};
      qenc_pkg::REG_START:    prdata = cfg_q.start_time;
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### sv/quadrature_encoder_accelerated_unit.sv
// Rotary quadrature encoder decoder with reversal hysteresis and acceleration.
// Top level; depends on qenc_pkg, qenc_cfg, qenc_ctrl, qenc_dp (and qenc_div).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one word per pin edge event,
//   action_i selects phase A, phase B or the button, with the new phase
//   levels, the edge kind and a millisecond timestamp. A word is taken at a
//   clock edge where in_valid_i is high and in_stall_o is low.
//   Output channel (out_valid_o / out_stall_i): zero or one result word per
//   input word, event_res_o (cw, ccw, pressed, released) and step_speed_o.
//   The result sits in an output register, so the next input word is taken
//   while an earlier result still waits for the receiver.
//   Timing: one word is worked on at a time. A step in the held direction
//   with a rising timestamp runs the interval average through the serial
//   divider, one quotient bit a cycle, after the evaluate and accumulate
//   states and before the push state. Other words with a result go from
//   evaluate straight to push; words without one go back to idle.
//   Reset: registers return to their defaults, direction is none, speed 1,
//   ring empty. A stalled receiver holds the result word and, once the next
//   result is ready, holds the block in its push state. The user writes the
//   APB-style port registers only while idle; the block does not enforce it.
module quadrature_encoder_accelerated_unit #(
  parameter int unsigned INTERVAL_SAMPLES = qenc_pkg::INTERVAL_SAMPLES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qenc_pkg::ADDR_W-1:0] paddr,
  input  logic [qenc_pkg::DATA_W-1:0] pwdata,
  output logic [qenc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic                        rising_i,
  input  logic                        phase_a_i,
  input  logic                        phase_b_i,
  input  logic [qenc_pkg::TIME_W-1:0] time_ms_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  event_res_o,
  output logic [3:0]                  step_speed_o
);

  qenc_pkg::cfg_t cfg;
  qenc_pkg::cmd_t cmd;
  qenc_pkg::sts_t sts;

  // Register file: limits, holdoff and start time
  qenc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: accept, evaluate, average, push
  qenc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Decode, hysteresis, interval ring and result register
  qenc_dp #(
    .INTERVAL_SAMPLES (INTERVAL_SAMPLES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (action_i),
    .rising_i     (rising_i),
    .phase_a_i    (phase_a_i),
    .phase_b_i    (phase_b_i),
    .time_ms_i    (time_ms_i),
    .event_res_o  (event_res_o),
    .step_speed_o (step_speed_o)
  );

endmodule

### sv/qenc_checker.sv
// Port-level checks for the encoder unit, bound to the top level.
// Depends on quadrature_encoder_accelerated_unit ports only.
module qenc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] event_res_o,
  input logic [3:0] step_speed_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) &&
    $stable(step_speed_o))
    else $error("result word changed while stalled");

  // Speed is always one of 1, 2, 4, 8
  a_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(step_speed_o))
    else $error("step speed not a power of two up to 8");

  // One word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in work");

  // A new result only comes out of a word in work
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a word in work");

endmodule

bind quadrature_encoder_accelerated_unit qenc_checker u_qenc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .event_res_o  (event_res_o),
  .step_speed_o (step_speed_o)
);

### tb/sv/tb.sv
// Self-checking testbench for quadrature_encoder_accelerated_unit: directed and random
// pin edge words, checked against an in-bench decoder model. Depends on qenc_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import qenc_pkg::*;

  // Action three is not a source the block knows; it must be dropped quietly.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned SAMPLES = INTERVAL_SAMPLES_DEF;
  // Room for the block to finish its last word, with margin, before touching registers.
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS = 150;

  typedef struct packed {
    logic [1:0]  evt;
    logic [3:0]  spd;
  } event_word_t;

  // One row of stimulus; typed rows carry their own expected result.
  typedef struct packed {
    logic [1:0]  action;
    logic        rising;
    logic        pa;
    logic        pb;
    logic [31:0] stamp;
    logic        typed;
    logic        has_res;
    logic [1:0]  evt;
    logic [3:0]  spd;
  } stim_row_t;

  function automatic stim_row_t no_result(input logic [1:0] act, input logic rise,
                                          input logic a, input logic b, input logic [31:0] t);
    stim_row_t r;
    r = '0;
    r.action = act; r.rising = rise; r.pa = a; r.pb = b; r.stamp = t;
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t with_result(input logic [1:0] act, input logic rise,
                                            input logic a, input logic b, input logic [31:0] t,
                                            input logic [1:0] e, input logic [3:0] s);
    stim_row_t r;
    r = no_result(act, rise, a, b, t);
    r.has_res = 1'b1; r.evt = e; r.spd = s;
    return r;
  endfunction

  function automatic stim_row_t predicted(input logic [1:0] act, input logic rise,
                                          input logic a, input logic b, input logic [31:0] t);
    stim_row_t r;
    r = no_result(act, rise, a, b, t);
    r.typed = 1'b0;
    return r;
  endfunction

  // Directed walk at reset settings (reversal 2, limits 20/40/80, holdoff 500, start 0).
  localparam stim_row_t DIRECTED_ROWS [23] = '{
    // action three with every bit set: dropped
    no_result(ACT_UNUSED, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF),
    // button inside the holdoff, then the same edge again
    no_result(ACT_BUTTON, 1'b1, 1'b0, 1'b0, 32'd100),
    no_result(ACT_BUTTON, 1'b1, 1'b0, 1'b0, 32'd1000),
    with_result(ACT_BUTTON, 1'b0, 1'b0, 1'b0, 32'd600, EVT_PRESSED, SPEED_1),
    with_result(ACT_BUTTON, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, EVT_RELEASED, SPEED_1),
    // exactly at the holdoff boundary: not past it yet
    no_result(ACT_BUTTON, 1'b0, 1'b0, 1'b0, 32'd500),
    with_result(ACT_BUTTON, 1'b1, 1'b0, 1'b0, 32'd501, EVT_RELEASED, SPEED_1),
    // first steps after reset are swallowed like a reversal
    no_result(ACT_PHASE_A, 1'b1, 1'b1, 1'b0, 32'd10),
    no_result(ACT_PHASE_A, 1'b0, 1'b0, 1'b1, 32'd20),
    with_result(ACT_PHASE_A, 1'b1, 1'b1, 1'b0, 32'd30, EVT_CCW, SPEED_1),
    predicted(ACT_PHASE_A, 1'b0, 1'b0, 1'b1, 32'd40),
    // falling edge word whose level rose: no step
    no_result(ACT_PHASE_A, 1'b0, 1'b1, 1'b0, 32'd50),
    predicted(ACT_PHASE_B, 1'b1, 1'b1, 1'b1, 32'd60),
    // repeated timestamp: speed drops to 1
    with_result(ACT_PHASE_B, 1'b0, 1'b0, 1'b0, 32'd60, EVT_CCW, SPEED_1),
    // reversal to clockwise: two swallowed, third accepted
    no_result(ACT_PHASE_B, 1'b1, 1'b0, 1'b1, 32'd70),
    no_result(ACT_PHASE_B, 1'b0, 1'b1, 1'b0, 32'd80),
    with_result(ACT_PHASE_B, 1'b1, 1'b0, 1'b1, 32'd90, EVT_CW, SPEED_1),
    predicted(ACT_PHASE_A, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF),
    // phase word without a level change
    no_result(ACT_PHASE_A, 1'b1, 1'b1, 1'b1, 32'd5),
    no_result(ACT_BUTTON, 1'b0, 1'b0, 1'b0, 32'd0),
    predicted(ACT_BUTTON, 1'b1, 1'b0, 1'b0, 32'h8000_0000),
    // rising flag with a falling level still steps
    predicted(ACT_PHASE_A, 1'b1, 1'b0, 1'b0, 32'd100),
    no_result(ACT_UNUSED, 1'b0, 1'b0, 1'b0, 32'd0)
  };

  // Block ports
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i = ACT_PHASE_A;
  logic                rising_i = 1'b0;
  logic                phase_a_i = 1'b0;
  logic                phase_b_i = 1'b0;
  logic [TIME_W-1:0]   time_ms_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          event_res_o;
  logic [3:0]          step_speed_o;

  // Decoder model state and its copy of the registers
  cfg_t                model_cfg;
  logic                lvl_a, lvl_b;
  logic [1:0]          held_dir;
  logic [7:0]          rev_count;
  logic [3:0]          speed;
  logic [31:0]         interval_ms [SAMPLES];
  int unsigned         ring_pos, ring_fill;
  logic [31:0]         prev_step_ms;
  logic [1:0]          last_btn;

  event_word_t         pending_events [$];
  event_word_t         arrived;
  int                  failures = 0;
  int                  quiet_cycles = 0;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  bit                  long_hold_go = 1'b0;
  bit                  hold_taken = 1'b0;
  int                  hold_left = 0;

  // Random stimulus: encoder wheel position, button level and a running clock
  logic                enc_a = 1'b0, enc_b = 1'b0, spin_cw = 1'b1, btn_rise = 1'b0;
  logic [31:0]         clock_ms = '0;
  int unsigned         pace_max = 60;

  quadrature_encoder_accelerated_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .rising_i     (rising_i),
    .phase_a_i    (phase_a_i),
    .phase_b_i    (phase_b_i),
    .time_ms_i    (time_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_res_o  (event_res_o),
    .step_speed_o (step_speed_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void model_reset();
    model_cfg.reversal_steps = RST_REVERSAL;
    model_cfg.fast_limit     = RST_FAST;
    model_cfg.medium_limit   = RST_MEDIUM;
    model_cfg.slow_limit     = RST_SLOW;
    model_cfg.press_holdoff  = RST_HOLDOFF;
    model_cfg.start_time     = RST_START;
    lvl_a = 1'b0; lvl_b = 1'b0;
    held_dir = DIR_NONE;
    rev_count = '0;
    speed = SPEED_1;
    foreach (interval_ms[i]) interval_ms[i] = '0;
    ring_pos = 0; ring_fill = 0;
    prev_step_ms = '0;
    last_btn = EDGE_NONE;
  endfunction

  // Push the new interval into the ring and map the average onto a speed.
  function automatic logic [3:0] speed_for_step(input logic [31:0] now);
    logic [63:0] sum;
    logic [63:0] avg;
    int unsigned i;
    if (now <= prev_step_ms) return SPEED_1;
    interval_ms[ring_pos] = now - prev_step_ms;
    ring_pos = (ring_pos + 1) % SAMPLES;
    if (ring_fill < SAMPLES) ring_fill++;
    sum = '0;
    for (i = 0; i < ring_fill; i++) sum += interval_ms[i];
    avg = sum / ring_fill;
    if (avg < model_cfg.fast_limit) return SPEED_8;
    if (avg < model_cfg.medium_limit) return SPEED_4;
    if (avg < model_cfg.slow_limit) return SPEED_2;
    return SPEED_1;
  endfunction

  // Returns 1 when the step is reported, 0 when it is swallowed.
  function automatic bit step_reported(input logic [1:0] dir, input logic [31:0] now);
    bit ok;
    logic [8:0] n;
    ok = 1'b1;
    if (held_dir == dir) begin
      speed = speed_for_step(now);
    end else begin
      n = {1'b0, rev_count} + 9'd1;
      if (n > {1'b0, model_cfg.reversal_steps}) begin
        rev_count = '0;
        held_dir = dir;
        speed = SPEED_1;
        ring_pos = 0;
        ring_fill = 0;
        foreach (interval_ms[i]) interval_ms[i] = '0;
      end else begin
        rev_count = n[7:0];
        ok = 1'b0;
      end
    end
    prev_step_ms = now;
    return ok;
  endfunction

  function automatic bit decode_event(input stim_row_t w, output event_word_t r);
    logic [1:0] btn_kind;
    logic       pa, pb;
    logic [1:0] dir;
    bit         found;
    r = '0;
    found = 1'b0;
    if (w.action == ACT_BUTTON) begin
      btn_kind = w.rising ? EDGE_RISE : EDGE_FALL;
      if (btn_kind == last_btn) return 1'b0;
      if (w.stamp >= model_cfg.start_time &&
          (w.stamp - model_cfg.start_time) > model_cfg.press_holdoff) begin
        r.evt = w.rising ? EVT_RELEASED : EVT_PRESSED;
        r.spd = speed;
        found = 1'b1;
      end
      last_btn = btn_kind;
      return found;
    end
    if (w.action == ACT_UNUSED) return 1'b0;
    pa = lvl_a; pb = lvl_b;
    lvl_a = w.pa; lvl_b = w.pb;
    dir = DIR_NONE;
    if (w.action == ACT_PHASE_A && w.pa != pa) begin
      if (w.rising && w.pa > pa) dir = w.pb ? DIR_CW : DIR_CCW;
      else if (w.pa < pa) dir = w.pb ? DIR_CCW : DIR_CW;
    end else if (w.action == ACT_PHASE_B && w.pb != pb) begin
      if (w.rising && w.pb > pb) dir = w.pa ? DIR_CCW : DIR_CW;
      else if (w.pb < pb) dir = w.pa ? DIR_CW : DIR_CCW;
    end
    if (dir != DIR_NONE && step_reported(dir, w.stamp)) begin
      r.evt = (dir == DIR_CW) ? EVT_CW : EVT_CCW;
      r.spd = speed;
      found = 1'b1;
    end
    return found;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Offer one word, hold it until taken, then queue what it should produce.
  task automatic send_word(input stim_row_t row);
    event_word_t want;
    bit          has_word;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    action_i   <= row.action;
    rising_i   <= row.rising;
    phase_a_i  <= row.pa;
    phase_b_i  <= row.pb;
    time_ms_i  <= row.stamp;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has_word = decode_event(row, want);
    if (row.typed) begin
      has_word = row.has_res;
      want.evt = row.evt;
      want.spd = row.spd;
    end
    if (has_word) pending_events.push_back(want);
    @(negedge clk_i);
  endtask

  // Drop valid, wait out every pending result, then let the block finish its last word.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write one register (junk above its width), read it back. Leaves psel high.
  task automatic set_register(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] readback;
    case (idx)
      REG_REVERSAL: mask = 32'h0000_00FF;
      REG_START:    mask = 32'hFFFF_FFFF;
      default:      mask = 32'h0000_FFFF;
    endcase
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & mask) | ($urandom() & ~mask);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    case (idx)
      REG_REVERSAL: model_cfg.reversal_steps = value[7:0];
      REG_FAST:     model_cfg.fast_limit     = value[15:0];
      REG_MEDIUM:   model_cfg.medium_limit   = value[15:0];
      REG_SLOW:     model_cfg.slow_limit     = value[15:0];
      REG_HOLDOFF:  model_cfg.press_holdoff  = value[15:0];
      default:      model_cfg.start_time     = value;
    endcase
    if ((readback & mask) !== (value & mask))
      note_failure($sformatf("register %0d read back %h, wrote %h", idx, readback & mask,
                             value & mask));
  endtask

  task automatic apply_settings(input cfg_t c);
    settle_block();
    set_register(REG_REVERSAL, {24'd0, c.reversal_steps});
    set_register(REG_FAST,     {16'd0, c.fast_limit});
    set_register(REG_MEDIUM,   {16'd0, c.medium_limit});
    set_register(REG_SLOW,     {16'd0, c.slow_limit});
    set_register(REG_HOLDOFF,  {16'd0, c.press_holdoff});
    set_register(REG_START,    c.start_time);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly a steadily running clock; now and then a repeat, a step back or any value.
  function automatic logic [31:0] next_stamp();
    case ($urandom_range(19))
      0: return clock_ms;
      1: return clock_ms - $urandom_range(1, 50);
      2: return $urandom();
      default: begin
        clock_ms = clock_ms + $urandom_range(1, pace_max);
        return clock_ms;
      end
    endcase
  endfunction

  task automatic run_random(input int count, input int tx_pct, input int rx_pct);
    stim_row_t row;
    int        pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    clock_ms = $urandom_range(0, 2000);
    for (int n = 0; n < count; n++) begin
      // halfway through, stop offering until every result is back
      if (n == count / 2) settle_block();
      row = '0;
      pick = $urandom_range(99);
      if (pick < 72) begin
        // well-formed quadrature step; runs reverse now and then and change pace
        if ($urandom_range(11) == 0) begin
          spin_cw = ~spin_cw;
          case ($urandom_range(3))
            0: pace_max = 8;
            1: pace_max = 25;
            2: pace_max = 60;
            default: pace_max = 300;
          endcase
        end
        if ((enc_a == enc_b) == spin_cw) begin
          enc_b = ~enc_b;
          row.action = ACT_PHASE_B;
          row.rising = enc_b;
        end else begin
          enc_a = ~enc_a;
          row.action = ACT_PHASE_A;
          row.rising = enc_a;
        end
        row.pa = enc_a;
        row.pb = enc_b;
      end else if (pick < 84) begin
        if ($urandom_range(4) != 0) btn_rise = ~btn_rise;
        row.action = ACT_BUTTON;
        row.rising = btn_rise;
        row.pa = $urandom_range(1);
        row.pb = $urandom_range(1);
      end else begin
        // noise: any action, any levels; resync the wheel to what was sent
        row.action = $urandom_range(3);
        row.rising = $urandom_range(1);
        row.pa = $urandom_range(1);
        row.pb = $urandom_range(1);
        if (row.action == ACT_PHASE_A || row.action == ACT_PHASE_B) begin
          enc_a = row.pa;
          enc_b = row.pb;
        end
      end
      row.stamp = next_stamp();
      send_word(row);
    end
  endtask

  // Receiver: random stall, plus one long hold-off counted here.
  always @(negedge clk_i) begin
    if (long_hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare every accepted result with the oldest expectation; track idle cycles.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        note_failure($sformatf("unexpected result: event %0d speed %0d",
                               event_res_o, step_speed_o));
      end else begin
        arrived = pending_events.pop_front();
        if (event_res_o !== arrived.evt || step_speed_o !== arrived.spd)
          note_failure($sformatf("event %0d speed %0d, expected event %0d speed %0d",
                                 event_res_o, step_speed_o, arrived.evt, arrived.spd));
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    cfg_t c;
    model_reset();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i]) send_word(DIRECTED_ROWS[i]);

    // low extremes: reverse at once, never speed 8, button live from the start
    c.reversal_steps = 8'd0;
    c.fast_limit     = 16'd0;
    c.medium_limit   = 16'd15;
    c.slow_limit     = 16'd45;
    c.press_holdoff  = 16'd0;
    c.start_time     = 32'd0;
    apply_settings(c);
    run_random(RANDOM_WORDS, 9, 59);

    // high extremes: reversals nearly never, button never past the holdoff
    c.reversal_steps = 8'hFF;
    c.fast_limit     = 16'hFFFF;
    c.medium_limit   = 16'hFFFF;
    c.slow_limit     = 16'hFFFF;
    c.press_holdoff  = 16'hFFFF;
    c.start_time     = 32'hFFFF_FFFF;
    apply_settings(c);
    run_random(RANDOM_WORDS, 59, 9);

    // mid-range random settings; the start time lands inside the random clock range
    c.reversal_steps = $urandom_range(0, 4);
    c.fast_limit     = $urandom_range(0, 40);
    c.medium_limit   = c.fast_limit + $urandom_range(0, 40);
    c.slow_limit     = c.medium_limit + $urandom_range(0, 60);
    c.press_holdoff  = $urandom_range(0, 300);
    c.start_time     = $urandom_range(0, 1500);
    apply_settings(c);
    // hold the receiver off while words keep coming, so the block backs up
    long_hold_go = 1'b1;
    run_random(RANDOM_WORDS, 0, 0);

    settle_block();
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
sv/qenc_pkg.sv
sv/qenc_div.sv
sv/qenc_dp.sv
sv/qenc_ctrl.sv
sv/qenc_cfg.sv
sv/quadrature_encoder_accelerated_unit.sv
sv/qenc_checker.sv
tb/sv/tb.sv
